// File: hdl/xbd_pkg.sv
// ----------------------------------------------------------------------------
// xbd_pkg
// Constants shared by the seeded xoshiro256** bounded draw block.
// ----------------------------------------------------------------------------
package xbd_pkg;

  localparam logic [63:0] GOLDEN_STEP = 64'd11400714819323198485;
  localparam logic [63:0] MIX_MUL_ONE = 64'd13787848793156543929;
  localparam logic [63:0] MIX_MUL_TWO = 64'd10723151780598845931;

  // significant bits kept when the scaled product is rounded
  localparam int unsigned FRAC_BITS = 53;

  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_DRAW   = 1'b1;

  typedef logic [63:0]  word_t;
  typedef logic [127:0] acc_t;

endpackage

// File: hdl/xbd_if.sv
// ----------------------------------------------------------------------------
// xbd_in_if / xbd_out_if
// Valid/ready channels for the request items and the draw results.
// ----------------------------------------------------------------------------
interface xbd_in_if #(
  parameter int BOUND_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [31:0]           seed_word;
  logic [BOUND_BITS-1:0] bound;

  modport source (output valid, output action, output seed_word, output bound,
                  input ready);
  modport sink   (input valid, input action, input seed_word, input bound,
                  output ready);
endinterface

interface xbd_out_if #(
  parameter int BOUND_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [63:0]           raw_value;
  logic [BOUND_BITS-1:0] bounded_value;

  modport source (output valid, output raw_value, output bounded_value,
                  input ready);
  modport sink   (input valid, input raw_value, input bounded_value,
                  output ready);
endinterface

// File: hdl/xoshiro256ss_bounded_draw.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_draw
// Seeded xoshiro256** generator with a bounded integer draw.
// ----------------------------------------------------------------------------
// One item at a time. A reseed (action 0) runs splitmix64 four times; a
// draw (action 1) delivers one result. Both are paced by the one shared
// 32x32 multiplier, which forms every 64-bit and the 53xBOUND_BITS-bit
// scaling product from partial products, and a draw also by the seven-step
// leading-zero search that locates the rounding point of the scaled product.
// in_chan.ready is high only while no item is in progress; a finished result
// sits in the output register until taken, and a new item may be accepted
// meanwhile.
module xoshiro256ss_bounded_draw
  import xbd_pkg::*;
#(
  parameter int BOUND_BITS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  xbd_in_if.sink     in_chan,
  xbd_out_if.source  out_chan
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MIX   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_POST  = 3'd3;
  localparam logic [2:0] ST_DRAW0 = 3'd4;
  localparam logic [2:0] ST_DRAW1 = 3'd5;
  localparam logic [2:0] ST_NORM  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  // rounding point: bit below the kept 53 bits of the normalised product
  localparam int unsigned HALF_POS = 128 - FRAC_BITS - 1;
  localparam logic [6:0]  LZ_ZERO  = 7'(128 - FRAC_BITS);
  localparam logic [6:0]  LZ_BIAS  = 7'(128 - 2 * FRAC_BITS);

  logic [2:0]            state_r, state_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic [2:0]            k_r, k_nxt;
  logic [6:0]            lz_r, lz_nxt;
  logic                  phase_r, phase_nxt;
  logic [1:0]            wcnt_r, wcnt_nxt;
  logic                  draw_r, draw_nxt;
  word_t                 ctr_r, ctr_nxt;
  word_t                 op_a_r, op_a_nxt;
  word_t                 op_b_r, op_b_nxt;
  word_t                 pp_r, pp_nxt;
  logic [1:0]            pp_sh_r, pp_sh_nxt;
  logic                  pp_v_r, pp_v_nxt;
  acc_t                  acc_r, acc_nxt;
  word_t                 tmp_r, tmp_nxt;
  word_t                 raw_r, raw_nxt;
  logic [BOUND_BITS-1:0] bnd_r, bnd_nxt;
  word_t                 wa_r, wa_nxt, wb_r, wb_nxt, wc_r, wc_nxt, wd_r, wd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  word_t                 out_raw_r, out_raw_nxt;
  logic [BOUND_BITS-1:0] out_bnd_r, out_bnd_nxt;

  logic [31:0] a_limb, b_limb;
  acc_t        pp_ext;
  logic [2:0]  n_pp;
  word_t       z_mix, rot_t, c1, d1, b1, mix_out;
  logic [52:0] q_keep;
  logic        rnd_up;
  logic [53:0] q_rnd, q_shr;
  logic [5:0]  shr;
  logic [6:0]  lz_off;

  // shared multiplier: one 32x32 partial product a cycle
  assign a_limb = cnt_r[1] ? op_a_r[63:32] : op_a_r[31:0];
  assign b_limb = cnt_r[0] ? op_b_r[63:32] : op_b_r[31:0];
  assign pp_nxt = 64'(a_limb) * 64'(b_limb);
  assign pp_ext = {64'd0, pp_r} << {pp_sh_r, 5'd0};
  // low 64 bits need three partial products, the full product four
  assign n_pp   = draw_r ? 3'd4 : 3'd3;

  assign z_mix   = ctr_r + GOLDEN_STEP;
  assign mix_out = acc_r[63:0] ^ (acc_r[63:0] >> 31);
  assign rot_t   = {tmp_r[56:0], tmp_r[63:57]};

  assign c1 = wc_r ^ wa_r;
  assign d1 = wd_r ^ wb_r;
  assign b1 = wb_r ^ c1;

  // round to nearest, ties to even, on the normalised product
  assign q_keep = acc_r[127:HALF_POS+1];
  assign rnd_up = acc_r[HALF_POS] && ((|acc_r[HALF_POS-1:0]) || q_keep[0]);
  assign q_rnd  = {1'b0, q_keep} + 54'(rnd_up);
  assign lz_off = lz_r - LZ_BIAS;
  assign shr    = lz_off[5:0];
  assign q_shr  = q_rnd >> shr;

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.raw_value     = out_raw_r;
  assign out_chan.bounded_value = out_bnd_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    lz_nxt        = lz_r;
    phase_nxt     = phase_r;
    wcnt_nxt      = wcnt_r;
    draw_nxt      = draw_r;
    ctr_nxt       = ctr_r;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    pp_sh_nxt     = pp_sh_r;
    pp_v_nxt      = 1'b0;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    raw_nxt       = raw_r;
    bnd_nxt       = bnd_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    wc_nxt        = wc_r;
    wd_nxt        = wd_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_raw_nxt   = out_raw_r;
    out_bnd_nxt   = out_bnd_r;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.action == ACT_RESEED) begin
            ctr_nxt   = {32'd0, in_chan.seed_word};
            wcnt_nxt  = 2'd0;
            draw_nxt  = 1'b0;
            state_nxt = ST_MIX;
          end else begin
            bnd_nxt   = in_chan.bound;
            draw_nxt  = 1'b1;
            state_nxt = ST_DRAW0;
          end
        end
      end
      ST_MIX: begin
        ctr_nxt   = z_mix;
        op_a_nxt  = z_mix ^ (z_mix >> 30);
        op_b_nxt  = MIX_MUL_ONE;
        phase_nxt = 1'b0;
        acc_nxt   = '0;
        cnt_nxt   = 3'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (pp_v_r) begin
          acc_nxt = acc_r + pp_ext;
        end
        if (cnt_r < n_pp) begin
          pp_v_nxt  = 1'b1;
          pp_sh_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
          cnt_nxt   = cnt_r + 3'd1;
        end else begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (draw_r) begin
          lz_nxt    = 7'd0;
          k_nxt     = 3'd0;
          state_nxt = ST_NORM;
        end else if (!phase_r) begin
          op_a_nxt  = acc_r[63:0] ^ (acc_r[63:0] >> 27);
          op_b_nxt  = MIX_MUL_TWO;
          phase_nxt = 1'b1;
          acc_nxt   = '0;
          cnt_nxt   = 3'd0;
          state_nxt = ST_MUL;
        end else begin
          // shift in at the last word: the first output ends in word_a
          wa_nxt   = wb_r;
          wb_nxt   = wc_r;
          wc_nxt   = wd_r;
          wd_nxt   = mix_out;
          wcnt_nxt = wcnt_r + 2'd1;
          if (wcnt_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MIX;
          end
        end
      end
      ST_DRAW0: begin
        tmp_nxt = wb_r + (wb_r << 2);
        wc_nxt  = c1 ^ (wb_r << 17);
        wb_nxt  = b1;
        wa_nxt  = wa_r ^ d1;
        wd_nxt  = {d1[18:0], d1[63:19]};
        state_nxt = ST_DRAW1;
      end
      ST_DRAW1: begin
        raw_nxt   = rot_t + (rot_t << 3);
        op_a_nxt  = raw_nxt >> 11;
        op_b_nxt  = 64'(bnd_r);
        acc_nxt   = '0;
        cnt_nxt   = 3'd0;
        state_nxt = ST_MUL;
      end
      ST_NORM: begin
        // leading-zero search, halving the step each cycle
        case (k_r)
          3'd0: if (acc_r[127:64] == '0) begin
            acc_nxt = acc_r << 64; lz_nxt = lz_r + 7'd64;
          end
          3'd1: if (acc_r[127:96] == '0) begin
            acc_nxt = acc_r << 32; lz_nxt = lz_r + 7'd32;
          end
          3'd2: if (acc_r[127:112] == '0) begin
            acc_nxt = acc_r << 16; lz_nxt = lz_r + 7'd16;
          end
          3'd3: if (acc_r[127:120] == '0) begin
            acc_nxt = acc_r << 8; lz_nxt = lz_r + 7'd8;
          end
          3'd4: if (acc_r[127:124] == '0) begin
            acc_nxt = acc_r << 4; lz_nxt = lz_r + 7'd4;
          end
          3'd5: if (acc_r[127:126] == '0) begin
            acc_nxt = acc_r << 2; lz_nxt = lz_r + 7'd2;
          end
          3'd6: if (!acc_r[127]) begin
            acc_nxt = acc_r << 1; lz_nxt = lz_r + 7'd1;
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd6) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = raw_r;
          // products of 53 bits or fewer scale to zero
          if (lz_r >= LZ_ZERO) begin
            out_bnd_nxt = '0;
          end else begin
            out_bnd_nxt = q_shr[BOUND_BITS-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      lz_r        <= '0;
      phase_r     <= 1'b0;
      wcnt_r      <= '0;
      draw_r      <= 1'b0;
      pp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wa_r        <= '0;
      wb_r        <= '0;
      wc_r        <= '0;
      wd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      lz_r        <= lz_nxt;
      phase_r     <= phase_nxt;
      wcnt_r      <= wcnt_nxt;
      draw_r      <= draw_nxt;
      pp_v_r      <= pp_v_nxt;
      out_valid_r <= out_valid_nxt;
      wa_r        <= wa_nxt;
      wb_r        <= wb_nxt;
      wc_r        <= wc_nxt;
      wd_r        <= wd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_r     <= ctr_nxt;
    op_a_r    <= op_a_nxt;
    op_b_r    <= op_b_nxt;
    pp_r      <= pp_nxt;
    pp_sh_r   <= pp_sh_nxt;
    acc_r     <= acc_nxt;
    tmp_r     <= tmp_nxt;
    raw_r     <= raw_nxt;
    bnd_r     <= bnd_nxt;
    out_raw_r <= out_raw_nxt;
    out_bnd_r <= out_bnd_nxt;
  end

endmodule
